// ===== rtl/lss_pkg.sv =====
`default_nettype none
package lss_pkg;

	localparam int RANGE_BITS         = 16;
	localparam int ANGLE_BITS         = 16;
	localparam int CLUSTER_INDEX_BITS = 8;
	localparam int CFG_BITS           = 16;
	localparam int POINT_BITS         = RANGE_BITS + 1;

	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE_STEP   = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DIST_THRESH  = 1'd1;
	localparam logic [CFG_BITS-1:0] ANGLE_STEP_RESET  = 16'd182;
	localparam logic [CFG_BITS-1:0] DIST_THRESH_RESET = 16'd100;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
	localparam int Q_FRAC       = 30;
	localparam int ACC_BITS     = RANGE_BITS + Q_FRAC + 3;
	localparam int Z_BITS       = 34;
	localparam logic [Q_FRAC-1:0] KINV_Q30 = 30'd652032874;

	localparam int IN_TDATA_BITS  = ((RANGE_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * POINT_BITS + CLUSTER_INDEX_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_TUSER_BITS = 2;

	typedef struct packed {
		logic [RANGE_BITS-1:0] range_mm;
		logic [1:0]            quadrant;
		logic [ANGLE_BITS-1:0] resid;
		logic                  last;
	} lss_req_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCALE,
		BK_ROTATE,
		BK_ROUND,
		BK_SQUARE,
		BK_COMPARE,
		BK_EMIT
	} lss_back_state_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [Q_FRAC-1:0] atan_turn32(input logic [STEP_BITS-1:0] i);
		logic [Q_FRAC-1:0] v;
		case (i)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lss_front.sv =====
`default_nettype none
module lss_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [lss_pkg::CFG_BITS-1:0]        angle_step,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [lss_pkg::RANGE_BITS-1:0]      in_range,
	input  wire logic                                in_last,
	output logic                                     push,
	output lss_pkg::lss_req_t                        push_req,
	input  wire logic                                q_full
);

	localparam int AB = lss_pkg::ANGLE_BITS;

	logic [AB-1:0] sample_angle_q;
	logic [AB-1:0] shifted;
	logic [1:0]    quad;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// nearest quadrant, residual kept within one eighth of a turn
	assign shifted = sample_angle_q + (AB'(1) << (AB - 3));
	assign quad    = shifted[AB-1:AB-2];

	always_comb begin
		push_req.range_mm = in_range;
		push_req.quadrant = quad;
		push_req.resid    = sample_angle_q - {quad, {(AB-2){1'b0}}};
		push_req.last     = in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_angle_q <= '0;
		end else if (push) begin
			if (in_last) begin
				sample_angle_q <= '0;
			end else begin
				sample_angle_q <= sample_angle_q + AB'(angle_step);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lss_queue.sv =====
`default_nettype none
module lss_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lss_pkg::lss_req_t push_req,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output lss_pkg::lss_req_t      head
);

	lss_pkg::lss_req_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lss_back.sv =====
`default_nettype none
module lss_back (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [lss_pkg::CFG_BITS-1:0]           dist_thresh,
	input  wire logic                                   q_valid,
	input  wire lss_pkg::lss_req_t                      q_head,
	output logic                                        q_pop,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [lss_pkg::OUT_TDATA_BITS-1:0]          out_data,
	output logic                                        out_last,
	output logic [lss_pkg::OUT_TUSER_BITS-1:0]          out_user
);

	localparam int RB   = lss_pkg::RANGE_BITS;
	localparam int PW   = lss_pkg::POINT_BITS;
	localparam int XW   = lss_pkg::ACC_BITS;
	localparam int ZW   = lss_pkg::Z_BITS;
	localparam int CW   = XW - lss_pkg::Q_FRAC;
	localparam int DW   = PW + 1;
	localparam int SQW  = 2 * DW;
	localparam int TW   = 2 * lss_pkg::CFG_BITS;
	localparam int SUMW = (SQW + 1 > TW) ? SQW + 1 : TW;
	localparam int CIB  = lss_pkg::CLUSTER_INDEX_BITS;
	localparam int PADW = lss_pkg::OUT_TDATA_BITS - lss_pkg::OUT_FIELD_BITS;
	localparam logic signed [CW-1:0] LIM = CW'((1 << RB) - 1);
	localparam logic [CIB-1:0] CMAX = '1;
	localparam logic [lss_pkg::STEP_BITS-1:0] LAST_STEP =
		lss_pkg::STEP_BITS'(lss_pkg::CORDIC_STEPS - 1);

	lss_pkg::lss_back_state_t state_q, state_d;

	logic [RB-1:0]                   range_q;
	logic [1:0]                      quad_q;
	logic                            last_q;
	logic signed [XW-1:0]            x_q, y_q;
	logic signed [ZW-1:0]            z_q;
	logic [lss_pkg::STEP_BITS-1:0]   iter_q;
	logic signed [PW-1:0]            px_q, py_q;
	logic [SQW-1:0]                  sq_px_q, sq_py_q, sq_fx_q, sq_fy_q;
	logic [TW-1:0]                   thr_sq_q;
	logic                            near_prev_q, near_first_q;

	logic signed [PW-1:0]            prev_x_q, prev_y_q, first_x_q, first_y_q;
	logic [CIB-1:0]                  count_q;
	logic                            started_q;

	logic                            out_valid_q;
	logic [lss_pkg::OUT_TDATA_BITS-1:0] out_data_q;
	logic                            out_last_q;
	logic [lss_pkg::OUT_TUSER_BITS-1:0] out_user_q;

	logic                            emit_go;
	logic signed [XW-1:0]            dx, dy;
	logic signed [ZW-1:0]            atan_z;
	logic signed [XW-1:0]            xr, yr;
	logic signed [CW-1:0]            c, s, qx, qy;
	logic signed [DW-1:0]            d_px, d_py, d_fx, d_fy;
	logic                            starts;
	logic [CIB-1:0]                  count_n;
	logic                            wraps;

	function automatic logic signed [PW-1:0] clamp(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		if (v > LIM) begin
			t = LIM;
		end else if (v < -LIM) begin
			t = -LIM;
		end else begin
			t = v;
		end
		return t[PW-1:0];
	endfunction

	assign emit_go = (state_q == lss_pkg::BK_EMIT) && (!out_valid_q || out_ready);
	assign q_pop   = (state_q == lss_pkg::BK_IDLE) && q_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lss_pkg::BK_IDLE:    if (q_valid) state_d = lss_pkg::BK_SCALE;
			lss_pkg::BK_SCALE:   state_d = lss_pkg::BK_ROTATE;
			lss_pkg::BK_ROTATE:  if (iter_q == LAST_STEP) state_d = lss_pkg::BK_ROUND;
			lss_pkg::BK_ROUND:   state_d = lss_pkg::BK_SQUARE;
			lss_pkg::BK_SQUARE:  state_d = lss_pkg::BK_COMPARE;
			lss_pkg::BK_COMPARE: state_d = lss_pkg::BK_EMIT;
			lss_pkg::BK_EMIT:    if (emit_go) state_d = lss_pkg::BK_IDLE;
			default:             state_d = lss_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lss_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one CORDIC micro-rotation per cycle
	assign dx     = y_q >>> iter_q;
	assign dy     = x_q >>> iter_q;
	assign atan_z = ZW'(lss_pkg::atan_turn32(iter_q));

	// round half up to whole mm, then undo the quadrant fold
	assign xr = x_q + (XW'(1) <<< (lss_pkg::Q_FRAC - 1));
	assign yr = y_q + (XW'(1) <<< (lss_pkg::Q_FRAC - 1));
	assign c  = CW'(xr >>> lss_pkg::Q_FRAC);
	assign s  = CW'(yr >>> lss_pkg::Q_FRAC);

	always_comb begin
		case (quad_q)
			2'd0:    begin qx = c;  qy = s;  end
			2'd1:    begin qx = -s; qy = c;  end
			2'd2:    begin qx = -c; qy = -s; end
			default: begin qx = s;  qy = -c; end
		endcase
	end

	assign d_px = DW'(px_q) - DW'(prev_x_q);
	assign d_py = DW'(py_q) - DW'(prev_y_q);
	assign d_fx = DW'(px_q) - DW'(first_x_q);
	assign d_fy = DW'(py_q) - DW'(first_y_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			lss_pkg::BK_IDLE: begin
				range_q <= q_head.range_mm;
				quad_q  <= q_head.quadrant;
				last_q  <= q_head.last;
				z_q     <= ZW'($signed(q_head.resid)) <<< (32 - lss_pkg::ANGLE_BITS);
			end
			lss_pkg::BK_SCALE: begin
				x_q    <= XW'(range_q) * XW'(lss_pkg::KINV_Q30);
				y_q    <= '0;
				iter_q <= '0;
			end
			lss_pkg::BK_ROTATE: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_z;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_z;
				end
				iter_q <= iter_q + 1'b1;
			end
			lss_pkg::BK_ROUND: begin
				px_q <= clamp(qx);
				py_q <= clamp(qy);
			end
			lss_pkg::BK_SQUARE: begin
				sq_px_q  <= SQW'(d_px * d_px);
				sq_py_q  <= SQW'(d_py * d_py);
				sq_fx_q  <= SQW'(d_fx * d_fx);
				sq_fy_q  <= SQW'(d_fy * d_fy);
				thr_sq_q <= TW'(dist_thresh) * TW'(dist_thresh);
			end
			lss_pkg::BK_COMPARE: begin
				near_prev_q  <= (SUMW'(sq_px_q) + SUMW'(sq_py_q)) <= SUMW'(thr_sq_q);
				near_first_q <= (SUMW'(sq_fx_q) + SUMW'(sq_fy_q)) <= SUMW'(thr_sq_q);
			end
			default: begin
			end
		endcase
	end

	// cluster bookkeeping
	always_comb begin
		if (!started_q) begin
			starts  = 1'b1;
			count_n = '0;
		end else if (near_prev_q) begin
			starts  = 1'b0;
			count_n = count_q;
		end else begin
			starts  = 1'b1;
			count_n = (count_q == CMAX) ? count_q : count_q + 1'b1;
		end
		wraps = last_q && (count_n != '0) && near_first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			count_q     <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
				prev_x_q    <= px_q;
				prev_y_q    <= py_q;
				if (!started_q) begin
					first_x_q <= px_q;
					first_y_q <= py_q;
				end
				if (last_q) begin
					count_q   <= '0;
					started_q <= 1'b0;
				end else begin
					count_q   <= count_n;
					started_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_data_q <= {{PADW{1'b0}}, count_n, py_q, px_q};
			out_last_q <= last_q;
			out_user_q <= {wraps, starts};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_user  = out_user_q;

endmodule
`default_nettype wire

// ===== rtl/lidar_scan_segmenter.sv =====
`default_nettype none
// Lidar scan breakpoint segmenter. Each request on the slave stream is one range
// sample (mm); tlast marks the scan's last sample. The sample angle is the sample
// number times angle_step (1/65536 turn). The block returns one result per sample:
// x,y in mm from a 24-step iterative CORDIC, the cluster number (saturates at 255),
// a new-cluster flag, and on the last sample whether the final cluster closes onto
// the first point. A sample holds the CORDIC/cluster engine through load, scale, 24
// rotations, round, square, compare and emit, and the engine takes no new sample
// until the last one is emitted; a two-entry request queue in front and the output
// register behind let both streams stall independently. Configuration writes are
// taken at any time but must only be issued while no sample is in flight.
module lidar_scan_segmenter (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [lss_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [lss_pkg::CFG_BITS-1:0]           cfg_data,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [lss_pkg::IN_TDATA_BITS-1:0]      s_tdata,   // range_mm
	input  wire logic                                   s_tlast,   // end_of_scan
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic [lss_pkg::OUT_TDATA_BITS-1:0]          m_tdata,   // point_x, point_y, cluster_index
	output logic                                        m_tlast,   // scan_done
	output logic [lss_pkg::OUT_TUSER_BITS-1:0]          m_tuser    // starts_cluster, wraps_to_first
);

	logic [lss_pkg::CFG_BITS-1:0] angle_step_q;
	logic [lss_pkg::CFG_BITS-1:0] dist_thresh_q;

	logic              push, q_full, q_pop, q_not_empty;
	lss_pkg::lss_req_t push_req, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_step_q  <= lss_pkg::ANGLE_STEP_RESET;
			dist_thresh_q <= lss_pkg::DIST_THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lss_pkg::CFG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				lss_pkg::CFG_DIST_THRESH: dist_thresh_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.angle_step (angle_step_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_range   (s_tdata[lss_pkg::RANGE_BITS-1:0]),
		.in_last    (s_tlast),
		.push       (push),
		.push_req   (push_req),
		.q_full     (q_full)
	);

	lss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_req  (push_req),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	lss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.dist_thresh (dist_thresh_q),
		.q_valid     (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_last    (m_tlast),
		.out_user    (m_tuser)
	);

endmodule
`default_nettype wire

// ===== rtl/lss_checker.sv =====
`default_nettype none
module lss_checker (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   m_tvalid,
	input  wire logic                                   m_tready,
	input  wire logic [lss_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
	input  wire logic                                   m_tlast,
	input  wire logic [lss_pkg::OUT_TUSER_BITS-1:0]     m_tuser
);

	localparam int PW  = lss_pkg::POINT_BITS;
	localparam int CIB = lss_pkg::CLUSTER_INDEX_BITS;
	localparam logic [PW-1:0] NEG_OVF = {1'b1, {(PW-1){1'b0}}};

	logic [PW-1:0]  px, py;
	logic [CIB-1:0] idx;

	assign px  = m_tdata[PW-1:0];
	assign py  = m_tdata[2*PW-1:PW];
	assign idx = m_tdata[2*PW+CIB-1:2*PW];

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

	// wrap flag only on the last sample of a scan
	a_wrap_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("wrap flag without scan end");

	// a wrap needs at least one break, so the closing cluster is never cluster zero
	a_wrap_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> idx != '0)
		else $error("wrap reported in a single-cluster scan");

	// saturation keeps coordinates symmetric
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> px != NEG_OVF && py != NEG_OVF)
		else $error("coordinate outside saturation range");

endmodule

bind lidar_scan_segmenter lss_checker u_lss_checker (.*);
`default_nettype wire
